[rtl/msc_pkg.sv]
package msc_pkg;

  localparam int unsigned MaxWordsDef = 65535;
  localparam int unsigned WordW       = 32;
  localparam int unsigned LenW        = 16;
  localparam int unsigned SimW        = 17;
  localparam int unsigned DivSteps    = 16;
  localparam int unsigned StepW       = $clog2(DivSteps);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic capture;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

[rtl/msc_in_if.sv]
interface msc_in_if;
  import msc_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] code_word;
  logic [WordW-1:0] pattern_word;
  logic [WordW-1:0] pattern_mask;
  logic [LenW-1:0]  pattern_length;
  logic [LenW-1:0]  available_words;
  logic [LenW-1:0]  routine_words;
  logic             last_item;

  modport source (
    output valid, code_word, pattern_word, pattern_mask, pattern_length,
           available_words, routine_words, last_item,
    input  ready
  );

  modport sink (
    input  valid, code_word, pattern_word, pattern_mask, pattern_length,
           available_words, routine_words, last_item,
    output ready
  );

endinterface

[rtl/msc_out_if.sv]
interface msc_out_if;
  import msc_pkg::*;

  logic            valid;
  logic            ready;
  logic            exact_match;
  logic [LenW-1:0] agree_count;
  logic [SimW-1:0] similarity;

  modport source (
    output valid, exact_match, agree_count, similarity,
    input  ready
  );

  modport sink (
    input  valid, exact_match, agree_count, similarity,
    output ready
  );

endinterface

[rtl/msc_datapath.sv]
module msc_datapath #(
  parameter int unsigned MaxWords = msc_pkg::MaxWordsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msc_pkg::cmd_t               cmd_i,
  output msc_pkg::sts_t               sts_o,
  input  logic [msc_pkg::WordW-1:0]   code_word_i,
  input  logic [msc_pkg::WordW-1:0]   pattern_word_i,
  input  logic [msc_pkg::WordW-1:0]   pattern_mask_i,
  input  logic [msc_pkg::LenW-1:0]    pattern_length_i,
  input  logic [msc_pkg::LenW-1:0]    available_words_i,
  input  logic [msc_pkg::LenW-1:0]    routine_words_i,
  output logic                        exact_match_o,
  output logic [msc_pkg::LenW-1:0]    agree_count_o,
  output logic [msc_pkg::SimW-1:0]    similarity_o
);
  import msc_pkg::*;

  localparam int unsigned PosW = $clog2(MaxWords + 1);

  logic [PosW-1:0]  position_q, position_d;
  logic [LenW-1:0]  agreements_q, agreements_d;
  logic             mismatch_q, mismatch_d;
  logic [StepW-1:0] step_q, step_d;

  logic [LenW-1:0]  mine, shorter, longer, pos_ext, agree_next;
  logic             agree, count_hit, mismatch_next, seen_ok, exact, far, sim_zero, sim_full;
  logic [LenW+1:0]  short_x4, long_x3;

  logic [LenW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  quot_q, quot_d;
  logic [LenW-1:0]  div_long_q;
  logic [LenW-1:0]  agree_cap_q;
  logic             exact_cap_q, zero_cap_q, full_cap_q;
  logic [LenW:0]    rem_shift;

  logic             exact_out_q;
  logic [LenW-1:0]  agree_out_q;
  logic [SimW-1:0]  sim_out_q, sim_sel;

  always_comb begin
    mine      = (routine_words_i < available_words_i) ? routine_words_i : available_words_i;
    shorter   = (pattern_length_i < mine) ? pattern_length_i : mine;
    longer    = (pattern_length_i > mine) ? pattern_length_i : mine;
    pos_ext   = LenW'(position_q);
    agree     = (code_word_i & pattern_mask_i) == pattern_word_i;
    count_hit = (pos_ext < shorter) && agree && (agreements_q != '1);
    agree_next    = count_hit ? agreements_q + LenW'(1) : agreements_q;
    mismatch_next = mismatch_q || ((pos_ext < pattern_length_i) && !agree);
    seen_ok   = ({1'b0, pos_ext} + (LenW+1)'(1)) >= {1'b0, pattern_length_i};
    exact     = (available_words_i >= pattern_length_i) && !mismatch_next && seen_ok;
    short_x4  = {shorter, 2'b00};
    long_x3   = {1'b0, longer, 1'b0} + {2'b00, longer};
    far       = short_x4 < long_x3;
    sim_zero  = (pattern_length_i == '0) || (mine == '0) || far;
    sim_full  = agree_next >= longer;
  end

  always_comb begin
    position_d   = position_q;
    agreements_d = agreements_q;
    mismatch_d   = mismatch_q;
    step_d       = step_q;
    if (cmd_i.capture) begin
      position_d   = '0;
      agreements_d = '0;
      mismatch_d   = 1'b0;
      step_d       = '0;
    end else if (cmd_i.accept) begin
      agreements_d = agree_next;
      mismatch_d   = mismatch_next;
      if (position_q < PosW'(MaxWords)) begin
        position_d = position_q + PosW'(1);
      end
    end
    if (cmd_i.div_step) begin
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= '0;
      agreements_q <= '0;
      mismatch_q   <= 1'b0;
      step_q       <= '0;
    end else begin
      position_q   <= position_d;
      agreements_q <= agreements_d;
      mismatch_q   <= mismatch_d;
      step_q       <= step_d;
    end
  end

  assign sts_o.div_last = (step_q == StepW'(DivSteps - 1));

  // Restoring division of the agreement count, scaled by 2^16, by the longer length.
  always_comb begin
    rem_shift = {rem_q, 1'b0};
    rem_d     = rem_q;
    quot_d    = quot_q;
    if (cmd_i.capture) begin
      rem_d  = agree_next;
      quot_d = '0;
    end else if (cmd_i.div_step) begin
      if (rem_shift >= {1'b0, div_long_q}) begin
        rem_d  = LenW'(rem_shift - {1'b0, div_long_q});
        quot_d = {quot_q[LenW-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift[LenW-1:0];
        quot_d = {quot_q[LenW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zero_cap_q) begin
      sim_sel = '0;
    end else if (full_cap_q) begin
      sim_sel = SimW'(1) << LenW;
    end else begin
      sim_sel = {1'b0, quot_q};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (cmd_i.capture) begin
      div_long_q  <= longer;
      agree_cap_q <= agree_next;
      exact_cap_q <= exact;
      zero_cap_q  <= sim_zero;
      full_cap_q  <= sim_full;
    end
    if (cmd_i.load_out) begin
      exact_out_q <= exact_cap_q;
      agree_out_q <= agree_cap_q;
      sim_out_q   <= sim_sel;
    end
  end

  assign exact_match_o = exact_out_q;
  assign agree_count_o = agree_out_q;
  assign similarity_o  = sim_out_q;

  a_capture_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |=> (position_q == '0) && (agreements_q == '0) && !mismatch_q)
    else $error("Accumulator not cleared after a comparison ended.");

  a_no_step_on_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.capture && cmd_i.div_step))
    else $error("Divider stepped while new operands were captured.");

endmodule

[rtl/msc_controller.sv]
module msc_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output msc_pkg::cmd_t cmd_o,
  input  msc_pkg::sts_t sts_i
);
  import msc_pkg::*;

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_DIV  = 3'b010,
    S_PUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_RUN: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_div_to_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_PUSH))
    else $error("Controller did not leave division after the last step.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("Pending result overwritten before it was taken.");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("Loaded result not presented.");

endmodule

[rtl/masked_signature_scorer.sv]
// Channel   Role     Handshake     Payload
// in_i      sink     valid/ready   code, signature, mask, lengths, last_item
// out_o     source   valid/ready   exact_match, agree_count, similarity
//
// Items that are not last are taken at one item per cycle.
// A last item starts a 16-step restoring divider, one step per cycle; the next item
// is taken only once the division has ended and the result has been loaded.
// The result sits in an output register, so the stream goes on while it waits.
// If a result is still not taken when the next division ends, the block waits.
// Reset is asynchronous and clears the counts and the output valid.
module masked_signature_scorer #(
  parameter int unsigned MaxWords = msc_pkg::MaxWordsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  msc_in_if.sink    in_i,
  msc_out_if.source out_o
);
  import msc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_item),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  msc_datapath #(
    .MaxWords (MaxWords)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .code_word_i       (in_i.code_word),
    .pattern_word_i    (in_i.pattern_word),
    .pattern_mask_i    (in_i.pattern_mask),
    .pattern_length_i  (in_i.pattern_length),
    .available_words_i (in_i.available_words),
    .routine_words_i   (in_i.routine_words),
    .exact_match_o     (out_o.exact_match),
    .agree_count_o     (out_o.agree_count),
    .similarity_o      (out_o.similarity)
  );

endmodule
